// ----- src/ssl_pkg.sv -----
// ----------------------------------------------------------------------------
// Smoothed sample logger package
// Shared constants, request codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ssl_pkg;

    // Ring depths and the widths that follow from them.
    localparam int RECENT_DEPTH = 256;
    localparam int DAY_DEPTH    = 128;
    localparam int REC_AW       = $clog2(RECENT_DEPTH);
    localparam int REC_CW       = $clog2(RECENT_DEPTH + 1);
    localparam int DAY_AW       = $clog2(DAY_DEPTH);
    localparam int DAY_CW       = $clog2(DAY_DEPTH + 1);

    // Fixed field widths.
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 16;
    localparam int IDX_W    = 8;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 17;
    localparam int RFILL_W  = 9;
    localparam int DFILL_W  = 8;
    localparam int ENTRY_W  = TIME_W + 2 * VAL_W;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 184;

    // Request codes carried in the slave tuser.
    localparam logic [REQ_W-1:0] REQ_LOG         = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ_RECENT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_DAY    = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic [0:0] CFG_DAY_PERIOD    = 1'b1;

    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RESET = 17'd60;
    localparam logic [CFG_W-1:0] DAY_PERIOD_RESET    = 17'd1800;

    typedef struct packed {
        logic load;       // latch the accepted request
        logic div_start;  // start the timestamp remainder
        logic log_write;  // commit a log request
        logic rd_issue;   // read both rings at the computed addresses
        logic out_load;   // capture the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

    typedef struct packed {
        logic                    entry_valid;
        logic [TIME_W-1:0]       entry_time;
        logic signed [VAL_W-1:0] entry_temperature;
        logic signed [VAL_W-1:0] entry_humidity;
        logic [RFILL_W-1:0]      recent_fill;
        logic [DFILL_W-1:0]      day_fill;
        logic signed [VAL_W-1:0] avg_temperature;
        logic signed [VAL_W-1:0] avg_humidity;
        logic                    day_captured;
        logic [TIME_W-1:0]       newest_recent_time;
        logic [TIME_W-1:0]       newest_day_time;
    } t_result;

endpackage

// ----- src/ssl_divider.sv -----
// ----------------------------------------------------------------------------
// Timestamp remainder unit
// Restoring bit-serial remainder of a 32-bit timestamp by a 17-bit period.
// ----------------------------------------------------------------------------
module ssl_divider import ssl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [CFG_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [CFG_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_quo;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_div;
    logic [CFG_W:0]    partial;
    logic [CFG_W-1:0]  n_rem;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        partial = {r_rem, r_quo[TIME_W-1]};
        if (partial >= {1'b0, r_div}) begin
            n_rem = CFG_W'(partial - {1'b0, r_div});
        end else begin
            n_rem = partial[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ----- src/ssl_datapath.sv -----
// ----------------------------------------------------------------------------
// Smoothed sample logger datapath
// Rings, averages, configuration, remainder unit and the output register.
// ----------------------------------------------------------------------------
module ssl_datapath import ssl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [REQ_W-1:0]    i_req,
    input  logic [S_DATA_W-1:0] i_data,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output t_result             o_result
);

    // Configuration.
    logic [CFG_W-1:0] r_sample_period;
    logic [CFG_W-1:0] r_day_period;

    // Latched request.
    logic [REQ_W-1:0]        r_req;
    logic [TIME_W-1:0]       r_time;
    logic signed [VAL_W-1:0] r_temp;
    logic signed [VAL_W-1:0] r_hum;
    logic [IDX_W-1:0]        r_idx;

    // Ring control and averages.
    logic [REC_AW-1:0]       r_rec_wptr;
    logic [REC_CW-1:0]       r_rec_cnt;
    logic [DAY_AW-1:0]       r_day_wptr;
    logic [DAY_CW-1:0]       r_day_cnt;
    logic signed [VAL_W-1:0] r_avg_t;
    logic signed [VAL_W-1:0] r_avg_h;
    logic                    r_seeded;
    logic [TIME_W-1:0]       r_newest_rec;
    logic [TIME_W-1:0]       r_newest_day;
    logic                    r_hit;
    logic                    r_captured;

    logic [ENTRY_W-1:0] r_rec_mem [RECENT_DEPTH];
    logic [ENTRY_W-1:0] r_day_mem [DAY_DEPTH];
    logic [ENTRY_W-1:0] r_rec_q;
    logic [ENTRY_W-1:0] r_day_q;
    t_result            r_result;

    logic                    div_done;
    logic [CFG_W-1:0]        div_rem;
    logic signed [VAL_W-1:0] n_avg_t;
    logic signed [VAL_W-1:0] n_avg_h;
    logic                    capture;
    logic [31:0]             rec_sum;
    logic [31:0]             day_sum;
    logic [REC_AW-1:0]       rec_addr;
    logic [DAY_AW-1:0]       day_addr;
    logic                    rec_hit;
    logic                    day_hit;
    logic [ENTRY_W-1:0]      sel_q;
    t_result                 result;

    // floor((15*s + x) / 16) with an arithmetic shift.
    function automatic logic signed [VAL_W-1:0] ema(input logic signed [VAL_W-1:0] s,
                                                    input logic signed [VAL_W-1:0] x);
        logic signed [VAL_W+5:0] v;
        v = (22'(s) <<< 4) - 22'(s) + 22'(x);
        return VAL_W'(v >>> 4);
    endfunction

    ssl_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_time),
        .i_divisor   (r_day_period),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    assign o_status.div_done = div_done;

    always_comb begin
        if (r_seeded) begin
            n_avg_t = ema(r_avg_t, r_temp);
            n_avg_h = ema(r_avg_h, r_hum);
        end else begin
            n_avg_t = r_temp;
            n_avg_h = r_hum;
        end
        // A zero period leaves the timestamp itself as the remainder.
        if (r_day_period == '0) begin
            capture = r_time < TIME_W'(r_sample_period);
        end else begin
            capture = div_rem < r_sample_period;
        end
    end

    // Oldest-first addressing: once a ring has wrapped, the oldest entry sits at the
    // write pointer. A hit's sum stays below twice the depth; one subtract wraps it.
    always_comb begin
        rec_hit = 32'(r_idx) < 32'(r_rec_cnt);
        day_hit = 32'(r_idx) < 32'(r_day_cnt);
        if (32'(r_rec_cnt) < RECENT_DEPTH) begin
            rec_sum = 32'(r_idx);
        end else begin
            rec_sum = 32'(r_rec_wptr) + 32'(r_idx);
            if (rec_sum >= RECENT_DEPTH) begin
                rec_sum = rec_sum - RECENT_DEPTH;
            end
        end
        if (32'(r_day_cnt) < DAY_DEPTH) begin
            day_sum = 32'(r_idx);
        end else begin
            day_sum = 32'(r_day_wptr) + 32'(r_idx);
            if (day_sum >= DAY_DEPTH) begin
                day_sum = day_sum - DAY_DEPTH;
            end
        end
        rec_addr = rec_sum[REC_AW-1:0];
        day_addr = day_sum[DAY_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RESET;
            r_day_period    <= DAY_PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                CFG_DAY_PERIOD:    r_day_period    <= i_cfg_data;
                default:           r_sample_period <= r_sample_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_time <= i_data[31:0];
            r_temp <= i_data[47:32];
            r_hum  <= i_data[63:48];
            r_idx  <= i_data[71:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_wptr   <= '0;
            r_rec_cnt    <= '0;
            r_day_wptr   <= '0;
            r_day_cnt    <= '0;
            r_avg_t      <= '0;
            r_avg_h      <= '0;
            r_seeded     <= 1'b0;
            r_newest_rec <= '0;
            r_newest_day <= '0;
            r_hit        <= 1'b0;
            r_captured   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hit      <= 1'b0;
                r_captured <= 1'b0;
            end
            if (i_cmd.rd_issue) begin
                case (r_req)
                    REQ_READ_RECENT: r_hit <= rec_hit;
                    REQ_READ_DAY:    r_hit <= day_hit;
                    default:         r_hit <= 1'b0;
                endcase
            end
            if (i_cmd.log_write) begin
                r_rec_wptr   <= (32'(r_rec_wptr) == RECENT_DEPTH - 1) ? '0
                                : r_rec_wptr + 1'b1;
                if (32'(r_rec_cnt) < RECENT_DEPTH) begin
                    r_rec_cnt <= r_rec_cnt + 1'b1;
                end
                r_newest_rec <= r_time;
                r_avg_t      <= n_avg_t;
                r_avg_h      <= n_avg_h;
                r_seeded     <= 1'b1;
                r_captured   <= capture;
                if (capture) begin
                    r_day_wptr   <= (32'(r_day_wptr) == DAY_DEPTH - 1) ? '0
                                    : r_day_wptr + 1'b1;
                    if (32'(r_day_cnt) < DAY_DEPTH) begin
                        r_day_cnt <= r_day_cnt + 1'b1;
                    end
                    r_newest_day <= r_time;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_write) begin
            r_rec_mem[r_rec_wptr] <= {r_time, r_temp, r_hum};
        end
        if (i_cmd.rd_issue) begin
            r_rec_q <= r_rec_mem[rec_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_write && capture) begin
            r_day_mem[r_day_wptr] <= {r_time, n_avg_t, n_avg_h};
        end
        if (i_cmd.rd_issue) begin
            r_day_q <= r_day_mem[day_addr];
        end
    end

    always_comb begin
        sel_q = (r_req == REQ_READ_DAY) ? r_day_q : r_rec_q;
        if (!r_hit) begin
            sel_q = '0;
        end
        result.entry_valid        = r_hit;
        result.entry_time         = sel_q[ENTRY_W-1 -: TIME_W];
        result.entry_temperature  = sel_q[2*VAL_W-1 -: VAL_W];
        result.entry_humidity     = sel_q[VAL_W-1:0];
        result.recent_fill        = RFILL_W'(r_rec_cnt);
        result.day_fill           = DFILL_W'(r_day_cnt);
        result.avg_temperature    = r_avg_t;
        result.avg_humidity       = r_avg_h;
        result.day_captured       = r_captured;
        result.newest_recent_time = r_newest_rec;
        result.newest_day_time    = r_newest_day;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= result;
        end
    end

    assign o_result = r_result;

endmodule

// ----- src/ssl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Smoothed sample logger controller
// Sequences one request at a time and owns both stream handshakes.
// ----------------------------------------------------------------------------
module ssl_ctrl import ssl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic [REQ_W-1:0] i_s_tuser,
    input  logic             i_m_tready,
    input  t_dp_status       i_status,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV_START = 6'b000010,
        S_DIV_WAIT  = 6'b000100,
        S_LOG       = 6'b001000,
        S_READ      = 6'b010000,
        S_DONE      = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (i_s_tuser)
                        REQ_LOG:         n_state = S_DIV_START;
                        REQ_READ_RECENT: n_state = S_READ;
                        REQ_READ_DAY:    n_state = S_READ;
                        default:         n_state = S_DONE;
                    endcase
                end
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                o_cmd.log_write = 1'b1;
                n_state         = S_DONE;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // The remainder only finishes while the controller waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> r_state == S_DIV_WAIT)
        else $error("remainder finished outside its wait state");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("a second request was taken while one was in flight");

    // A result that is loaded shows up as a valid output in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

// ----- src/smoothed_sample_logger_top.sv -----
// ----------------------------------------------------------------------------
// Smoothed sample logger
// Ring-buffer sample logger with exponential smoothing and day decimation.
// ----------------------------------------------------------------------------
// A log request reaches a valid result only once the bit-serial remainder of the
// timestamp by the day period is done; a read passes through the registered ring read.
// One request is handled at a time; the next one is accepted in the cycle after the
// result is registered.
// Reset (synchronous, active low) clears fill counts, pointers, averages and the seed flag
// and restores the periods to 60 and 1800 seconds; ring contents are not cleared.
module smoothed_sample_logger_top import ssl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // Request stream.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // tdata, from bit 0: sample_time[32], temperature[16], humidity[16], read_index[8].
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // tuser: req_type[2].
    input  logic [REQ_W-1:0]    i_s_tuser,
    // Result stream.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // tdata, from bit 0: entry_valid[1], entry_time[32], entry_temperature[16],
    // entry_humidity[16], recent_fill[9], day_fill[8], avg_temperature[16],
    // avg_humidity[16], day_captured[1], newest_recent_time[32], newest_day_time[32],
    // then five zero bits.
    output logic [M_DATA_W-1:0] o_m_tdata
);

    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    result;

    // The controller sequences each request; every step it takes shows up as a
    // command to the datapath, which reports back only when the remainder is done.
    ssl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    // The datapath holds both rings, the averages and the output register, so a
    // finished result can wait for the downstream side while the next request enters.
    ssl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    // Pack the result fields with the first field in the lowest bits.
    assign o_m_tdata = {5'b0,
                        result.newest_day_time,
                        result.newest_recent_time,
                        result.day_captured,
                        result.avg_humidity,
                        result.avg_temperature,
                        result.day_fill,
                        result.recent_fill,
                        result.entry_humidity,
                        result.entry_temperature,
                        result.entry_time,
                        result.entry_valid};

endmodule

// ----- verif/tb_smoothed_sample_logger_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smoothed sample logger testbench
// Drives log and read requests into the request stream and compares every
// response, field by field, against an in-bench model of both rings and the
// smoothed averages, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_smoothed_sample_logger_top;
    import ssl_pkg::*;

    // The request type that the block treats as a no-op.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF_NS       = 4;
    localparam int RESET_CYCLES      = 10;
    // The settle is longer than a log request takes, so it is enough to catch
    // anything spurious after the last response.
    localparam int END_SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int SINK_HOLD_CYCLES  = 400;
    // The slowest correct run is well under 2 ms; this leaves a wide margin.
    localparam int RUN_LIMIT_NS      = 8_000_000;

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [0:0]          i_cfg_index = CFG_SAMPLE_PERIOD;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic [REQ_W-1:0]    i_s_tuser   = REQ_LOG;
    logic                i_m_tready  = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;

    smoothed_sample_logger_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Logger model: both rings, their pointers and counts, the averages, the
    // seed flag and the two period registers, all at the block's widths.
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]       recent_time_log [RECENT_DEPTH];
    logic signed [VAL_W-1:0] recent_temp_log [RECENT_DEPTH];
    logic signed [VAL_W-1:0] recent_hum_log  [RECENT_DEPTH];
    logic [TIME_W-1:0]       day_time_log    [DAY_DEPTH];
    logic signed [VAL_W-1:0] day_temp_log    [DAY_DEPTH];
    logic signed [VAL_W-1:0] day_hum_log     [DAY_DEPTH];
    logic [REC_AW-1:0]       rec_wr_ptr        = '0;
    logic [REC_CW-1:0]       rec_count         = '0;
    logic [DAY_AW-1:0]       day_wr_ptr        = '0;
    logic [DAY_CW-1:0]       day_count         = '0;
    logic signed [VAL_W-1:0] avg_temp          = '0;
    logic signed [VAL_W-1:0] avg_hum           = '0;
    logic                    avg_seeded        = 1'b0;
    logic [CFG_W-1:0]        sample_period_reg = SAMPLE_PERIOD_RESET;
    logic [CFG_W-1:0]        day_period_reg    = DAY_PERIOD_RESET;

    // Responses predicted for accepted requests, oldest first.
    t_result pending_responses [$];
    int      mismatch_count = 0;

    // Idling controls, written only by the test sequence.
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int hold_requests  = 0;

    // One step of the exponential average: floor((15 * avg + x) / 16).
    // The arithmetic shift of the 32-bit sum gives the floor directly.
    function automatic logic signed [VAL_W-1:0] smooth_step(
        input logic signed [VAL_W-1:0] avg,
        input logic signed [VAL_W-1:0] x
    );
        int acc;
        acc = 15 * int'(avg) + int'(x);
        return VAL_W'(acc >>> 4);
    endfunction

    // Applies one request to the model and returns the response it causes.
    function automatic t_result predict_logger_response(
        input logic [REQ_W-1:0]        req,
        input logic [TIME_W-1:0]       stamp,
        input logic signed [VAL_W-1:0] temp,
        input logic signed [VAL_W-1:0] hum,
        input logic [IDX_W-1:0]        idx
    );
        t_result           rsp;
        logic [TIME_W-1:0] remainder;
        logic [REC_AW-1:0] rec_slot;
        logic [DAY_AW-1:0] day_slot;
        rsp = '0;
        case (req)
            REQ_LOG: begin
                recent_time_log[rec_wr_ptr] = stamp;
                recent_temp_log[rec_wr_ptr] = temp;
                recent_hum_log[rec_wr_ptr]  = hum;
                rec_wr_ptr = rec_wr_ptr + 1'b1;
                if (rec_count < RECENT_DEPTH) begin
                    rec_count = rec_count + 1'b1;
                end
                // The first sample after reset loads the averages directly.
                if (!avg_seeded) begin
                    avg_temp   = temp;
                    avg_hum    = hum;
                    avg_seeded = 1'b1;
                end else begin
                    avg_temp = smooth_step(avg_temp, temp);
                    avg_hum  = smooth_step(avg_hum, hum);
                end
                // A zero day period leaves the timestamp itself as the
                // remainder, as the datapath does on a zero period.
                remainder = (day_period_reg == '0) ? stamp : stamp % day_period_reg;
                if (remainder < sample_period_reg) begin
                    day_time_log[day_wr_ptr] = stamp;
                    day_temp_log[day_wr_ptr] = avg_temp;
                    day_hum_log[day_wr_ptr]  = avg_hum;
                    day_wr_ptr = day_wr_ptr + 1'b1;
                    if (day_count < DAY_DEPTH) begin
                        day_count = day_count + 1'b1;
                    end
                    rsp.day_captured = 1'b1;
                end
            end
            REQ_READ_RECENT: begin
                if (idx < rec_count) begin
                    // Once full, the oldest entry sits at the write pointer.
                    rec_slot = (rec_count < RECENT_DEPTH) ? idx : rec_wr_ptr + idx;
                    rsp.entry_valid       = 1'b1;
                    rsp.entry_time        = recent_time_log[rec_slot];
                    rsp.entry_temperature = recent_temp_log[rec_slot];
                    rsp.entry_humidity    = recent_hum_log[rec_slot];
                end
            end
            REQ_READ_DAY: begin
                if (idx < day_count) begin
                    day_slot = (day_count < DAY_DEPTH) ? idx[DAY_AW-1:0]
                                                       : day_wr_ptr + idx[DAY_AW-1:0];
                    rsp.entry_valid       = 1'b1;
                    rsp.entry_time        = day_time_log[day_slot];
                    rsp.entry_temperature = day_temp_log[day_slot];
                    rsp.entry_humidity    = day_hum_log[day_slot];
                end
            end
            default: begin
                // The unused request type changes nothing.
            end
        endcase
        rec_slot = rec_wr_ptr - 1'b1;
        day_slot = day_wr_ptr - 1'b1;
        rsp.recent_fill        = rec_count;
        rsp.day_fill           = day_count;
        rsp.avg_temperature    = avg_temp;
        rsp.avg_humidity       = avg_hum;
        rsp.newest_recent_time = (rec_count != '0) ? recent_time_log[rec_slot] : '0;
        rsp.newest_day_time    = (day_count != '0) ? day_time_log[day_slot] : '0;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------------

    // Idle length for either stream: mostly none or short, a few long.
    function automatic int unsigned pick_idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Half the timestamps land just around a multiple of the day period so
    // that the capture window is hit often and its edge is crossed.
    function automatic logic [TIME_W-1:0] pick_sample_time();
        logic [TIME_W-1:0] base;
        if ($urandom_range(0, 1) == 0) return $urandom;
        if (day_period_reg == '0) return $urandom_range(0, sample_period_reg + 2);
        base = $urandom_range(0, 32'hFFFF_FFFF / day_period_reg) * day_period_reg;
        return base + $urandom_range(0, sample_period_reg + 2);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Read indexes mostly fall inside the filled part of the ring, with a
    // share right at its end and a share anywhere in the index range.
    function automatic logic [IDX_W-1:0] pick_read_index(input int unsigned fill);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25 || fill == 0) return IDX_W'($urandom_range(0, 255));
        if (roll < 40) return (fill > 255) ? 8'd255 : IDX_W'(fill - $urandom_range(0, 1));
        return IDX_W'($urandom_range(0, fill - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Inputs change at the falling edge; a request is taken at
    // the rising edge where tvalid and tready are both high. With no idle
    // cycles after it, tvalid stays high for the next request.
    // ------------------------------------------------------------------------
    task automatic send_request(
        input logic [REQ_W-1:0]        req,
        input logic [TIME_W-1:0]       stamp,
        input logic signed [VAL_W-1:0] temp,
        input logic signed [VAL_W-1:0] hum,
        input logic [IDX_W-1:0]        idx
    );
        int unsigned gap;
        @(negedge i_clk);
        i_s_tuser  = req;
        i_s_tdata  = {idx, hum, temp, stamp};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_responses.push_back(predict_logger_response(req, stamp, temp, hum, idx));
        gap = src_gaps_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random_request();
        logic [REQ_W-1:0] req;
        int unsigned      roll;
        int unsigned      fill;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            req = REQ_LOG;
        end else if (roll < 72) begin
            req = REQ_READ_RECENT;
        end else if (roll < 96) begin
            req = REQ_READ_DAY;
        end else begin
            req = REQ_UNUSED;
        end
        fill = (req == REQ_READ_DAY) ? 32'(day_count) : 32'(rec_count);
        send_request(req, pick_sample_time(), pick_value(), pick_value(), pick_read_index(fill));
    endtask

    // Drops tvalid and waits until every predicted response has come back.
    task automatic wait_for_responses();
        int waited;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        waited = 0;
        while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Registers are only written with the block idle, so the model takes the
    // new value at once.
    task automatic write_register(input logic [0:0] index, input logic [CFG_W-1:0] value);
        wait_for_responses();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        if (index == CFG_SAMPLE_PERIOD) begin
            sample_period_reg = value;
        end else begin
            day_period_reg = value;
        end
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side. The receiver idles at random and, on request from the
    // test sequence, holds tready low for a long stretch that it counts
    // itself.
    // ------------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = SINK_HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_m_tready = 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else begin
            i_m_tready = 1'b1;
            if (sink_stalls_on && $urandom_range(0, 99) < 40) begin
                stall_left = pick_idle_len();
            end
        end
    end

    function automatic void check_field(
        input string             name,
        input logic [TIME_W-1:0] want_val,
        input logic [TIME_W-1:0] got_val
    );
        if (got_val !== want_val) begin
            mismatch_count++;
            $display("%0d ns: %s mismatch, expected %h, actual %h",
                     $time, name, want_val, got_val);
        end
    endfunction

    // Every accepted response is compared with the oldest prediction. The
    // tdata slices follow the packing listed at the block's port. Signed
    // fields are compared as plain bit patterns.
    always @(posedge i_clk) begin : response_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                $display("%0d ns: response with no request outstanding, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want = pending_responses.pop_front();
                check_field("entry_valid",        want.entry_valid,        o_m_tdata[0]);
                check_field("entry_time",         want.entry_time,         o_m_tdata[32:1]);
                check_field("entry_temperature",  $unsigned(want.entry_temperature),
                            o_m_tdata[48:33]);
                check_field("entry_humidity",     $unsigned(want.entry_humidity),
                            o_m_tdata[64:49]);
                check_field("recent_fill",        want.recent_fill,        o_m_tdata[73:65]);
                check_field("day_fill",           want.day_fill,           o_m_tdata[81:74]);
                check_field("avg_temperature",    $unsigned(want.avg_temperature),
                            o_m_tdata[97:82]);
                check_field("avg_humidity",       $unsigned(want.avg_humidity),
                            o_m_tdata[113:98]);
                check_field("day_captured",       want.day_captured,       o_m_tdata[114]);
                check_field("newest_recent_time", want.newest_recent_time, o_m_tdata[146:115]);
                check_field("newest_day_time",    want.newest_day_time,    o_m_tdata[178:147]);
                check_field("padding",            '0,                      o_m_tdata[183:179]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reads and the unused request type while both rings are still empty.
    task automatic test_empty_rings();
        send_request(REQ_READ_RECENT, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 8'd0);
        send_request(REQ_READ_RECENT, 32'h0, 16'sh0, 16'sh0, 8'd255);
        send_request(REQ_READ_DAY, 32'h0, 16'sh0, 16'sh0, 8'd0);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF, 8'd255);
    endtask

    // Under the reset periods: the seeding sample, value extremes, both edges
    // of the capture window, and reads inside and just past each fill count.
    task automatic test_seed_and_extremes();
        send_request(REQ_LOG, 32'd0,          16'sh7FFF, 16'sh8000, 8'd0);
        send_request(REQ_LOG, 32'd59,         16'sh8000, 16'sh7FFF, 8'd255);
        send_request(REQ_LOG, 32'd60,         16'sh0000, 16'sh0000, 8'd0);
        send_request(REQ_LOG, 32'd1799,       16'shFFFF, 16'sh0001, 8'd0);
        send_request(REQ_LOG, 32'd1800,       16'sh0100, 16'shFF00, 8'd0);
        send_request(REQ_LOG, 32'hFFFF_FFFF,  16'sh7FFF, 16'sh7FFF, 8'd0);
        send_request(REQ_UNUSED, 32'd0,       16'sh0,    16'sh0,    8'd0);
        send_request(REQ_READ_RECENT, 32'd0,  16'sh0,    16'sh0,    8'd0);
        send_request(REQ_READ_RECENT, 32'd0,  16'sh0,    16'sh0,    8'd5);
        send_request(REQ_READ_RECENT, 32'd0,  16'sh0,    16'sh0,    8'd6);
        send_request(REQ_READ_RECENT, 32'd0,  16'sh0,    16'sh0,    8'd255);
        send_request(REQ_READ_DAY, 32'd0,     16'sh0,    16'sh0,    8'd0);
        send_request(REQ_READ_DAY, 32'd0,     16'sh0,    16'sh0,    8'd2);
        send_request(REQ_READ_DAY, 32'd0,     16'sh0,    16'sh0,    8'd3);
        send_request(REQ_READ_DAY, 32'd0,     16'sh0,    16'sh0,    8'd255);
    endtask

    // Zero and full-scale periods, including a zero day period where the
    // timestamp itself is compared with the window.
    task automatic test_register_extremes();
        write_register(CFG_SAMPLE_PERIOD, 17'd0);
        write_register(CFG_DAY_PERIOD, 17'd0);
        send_request(REQ_LOG, 32'd0, pick_value(), pick_value(), 8'd0);
        write_register(CFG_SAMPLE_PERIOD, 17'h1FFFF);
        send_request(REQ_LOG, 32'h1FFFE, pick_value(), pick_value(), 8'd0);
        send_request(REQ_LOG, 32'h1FFFF, pick_value(), pick_value(), 8'd0);
        write_register(CFG_SAMPLE_PERIOD, 17'd1);
        write_register(CFG_DAY_PERIOD, 17'd1);
        send_request(REQ_LOG, $urandom, pick_value(), pick_value(), 8'd0);
        write_register(CFG_DAY_PERIOD, 17'h1FFFF);
        send_request(REQ_LOG, 32'h1FFFF * 3, pick_value(), pick_value(), 8'd0);
    endtask

    // With every log captured, both rings overflow; reads then cover the
    // oldest, newest and middle entries and indexes past the day depth.
    task automatic test_ring_wraparound();
        int n;
        write_register(CFG_SAMPLE_PERIOD, 17'd1);
        write_register(CFG_DAY_PERIOD, 17'd1);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        for (n = 0; n < 300; n++) begin
            send_request(REQ_LOG, $urandom, pick_value(), pick_value(),
                         IDX_W'($urandom_range(0, 255)));
        end
        send_request(REQ_READ_RECENT, $urandom, pick_value(), pick_value(), 8'd0);
        send_request(REQ_READ_RECENT, $urandom, pick_value(), pick_value(), 8'd255);
        send_request(REQ_READ_RECENT, $urandom, pick_value(), pick_value(), 8'd128);
        send_request(REQ_READ_DAY, $urandom, pick_value(), pick_value(), 8'd0);
        send_request(REQ_READ_DAY, $urandom, pick_value(), pick_value(), 8'd127);
        send_request(REQ_READ_DAY, $urandom, pick_value(), pick_value(), 8'd128);
        send_request(REQ_READ_DAY, $urandom, pick_value(), pick_value(), 8'd255);
        for (n = 0; n < 33; n++) begin
            send_request($urandom_range(0, 1) ? REQ_READ_RECENT : REQ_READ_DAY,
                         $urandom, pick_value(), pick_value(),
                         IDX_W'($urandom_range(0, 255)));
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // back to back, so the block fills up and stalls its request side. Then
    // the sender pauses until every response is in before it goes on.
    task automatic test_output_backpressure();
        int n;
        wait_for_responses();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        hold_requests++;
        for (n = 0; n < 24; n++) begin
            send_random_request();
        end
        wait_for_responses();
        for (n = 0; n < 8; n++) begin
            send_random_request();
        end
    endtask

    // Random traffic over several period settings, each with its own mix of
    // idling on the two streams, including stretches with none at all.
    task automatic test_random_traffic();
        int               phase;
        int               n;
        logic [CFG_W-1:0] sp;
        logic [CFG_W-1:0] dp;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    sp = SAMPLE_PERIOD_RESET;
                    dp = DAY_PERIOD_RESET;
                end
                1: begin
                    sp = 17'd1;
                    dp = 17'd1;
                end
                2: begin
                    sp = 17'd0;
                    dp = 17'd7;
                end
                3: begin
                    sp = 17'd5;
                    dp = 17'd0;
                end
                4: begin
                    sp = 17'h1FFFF;
                    dp = 17'h1FFFF;
                end
                5: begin
                    sp = 17'd1;
                    dp = 17'h1FFFF;
                end
                6: begin
                    sp = CFG_W'($urandom_range(1, 86400));
                    dp = CFG_W'($urandom_range(1, 86400));
                end
                default: begin
                    sp = CFG_W'($urandom_range(1, 20));
                    dp = CFG_W'($urandom_range(2, 100));
                end
            endcase
            write_register(CFG_SAMPLE_PERIOD, sp);
            write_register(CFG_DAY_PERIOD, dp);
            src_gaps_on    = (phase % 4 == 0) || (phase % 4 == 2);
            sink_stalls_on = (phase % 4 == 0) || (phase % 4 == 3);
            for (n = 0; n < 135; n++) begin
                send_random_request();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: one reset, then the tests in turn, then a drain and a settle
    // before the verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_rings();
        test_seed_and_extremes();
        test_register_extremes();
        test_ring_wraparound();
        test_output_backpressure();
        test_random_traffic();

        wait_for_responses();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (pending_responses.size() != 0) begin
            mismatch_count += pending_responses.size();
            $display("%0d ns: %0d predicted responses never arrived",
                     $time, pending_responses.size());
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a block that stops answering.
    initial begin
        #RUN_LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
src/ssl_pkg.sv
src/ssl_divider.sv
src/ssl_datapath.sv
src/ssl_ctrl.sv
src/smoothed_sample_logger_top.sv
verif/tb_smoothed_sample_logger_top.sv
